/* design/number_to_display_text_formatter_core_macros.svh */
// ----------------------------------------------------------------------------
// Number to display text formatter: assertion macros
// Concurrent assertion wrappers shared by the formatter modules.
// ----------------------------------------------------------------------------
`ifndef NUMBER_TO_DISPLAY_TEXT_FORMATTER_CORE_MACROS_SVH
`define NUMBER_TO_DISPLAY_TEXT_FORMATTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define NTDF_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("ntdf assertion failed");
`define NTDF_ASSERT_NEVER(lbl, ck, rn, cond) \
  `NTDF_ASSERT(lbl, ck, rn, !(cond))
`else
`define NTDF_ASSERT(lbl, ck, rn, prop)
`define NTDF_ASSERT_NEVER(lbl, ck, rn, cond)
`endif

`endif

/* design/ntdf_pkg.sv */
// ----------------------------------------------------------------------------
// Number to display text formatter: package
// Shared item type, slot count, glyph, mode and dot constants and glyph helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ntdf_pkg;

  localparam int unsigned NSLOTS = 5;

  localparam logic [7:0] GLYPH_ZERO  = 8'h30;
  localparam logic [7:0] GLYPH_SPACE = 8'h20;
  localparam logic [7:0] GLYPH_DOT   = 8'h2e;

  localparam logic [1:0] MODE_DEC   = 2'd0;
  localparam logic [1:0] MODE_BLANK = 2'd1;

  localparam logic [1:0] DOT_NONE  = 2'd0;
  localparam logic [1:0] DOT_ONE   = 2'd1;
  localparam logic [1:0] DOT_TWO   = 2'd2;
  localparam logic [1:0] DOT_THREE = 2'd3;

  typedef struct packed {
    logic [4:0]       start;
    logic [2:0]       count;
    logic [1:0]       dot;
    logic [4:0]       wmask;
    logic [4:0][7:0]  glyph;
  } item_t;

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    logic [7:0] g;
    if (nib < 4'd10) begin
      g = 8'h30 + {4'b0, nib};
    end else begin
      g = 8'h37 + {4'b0, nib};
    end
    return g;
  endfunction

endpackage

`default_nettype wire

/* design/number_to_display_text_formatter_core.sv */
// ----------------------------------------------------------------------------
// Number to display text formatter: top level
// Turns a 16-bit value into display characters, one character per transfer.
// ----------------------------------------------------------------------------
// Input channel (in_*): value, mode (decimal, decimal with leading-zero
// blanking, hexadecimal), start cell, digit count and dot place.
// Output channel (out_*): one character per transfer with its cell index;
// out_last marks the final character of an item. A count of zero emits
// nothing but still updates the five held digit slots.
// A decimal item holds the front for the transfer and then four
// compare-and-subtract steps, the last giving two digits; a hex item
// is ready as soon as it is taken. The front accepts a new item as its
// current one goes into the queue. The back end emits one character
// per cycle while the receiver is ready, and pops another item from the
// queue as it emits the last character of the current one.
// A two-entry queue sits between front and back; a stalled receiver holds
// the output register, fills the queue and then drops in_ready.
// Reset clears the digit slots to zero and empties every stage.
// ----------------------------------------------------------------------------
`default_nettype none

module number_to_display_text_formatter_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [15:0]   in_value,
  input  wire logic [1:0]    in_mode,
  input  wire logic [4:0]    in_start_cell,
  input  wire logic [2:0]    in_digit_count,
  input  wire logic [1:0]    in_dot_place,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [5:0]         out_cell_res,
  output logic [7:0]         out_glyph,
  output logic               out_last
);

  ntdf_pkg::item_t push_data;
  ntdf_pkg::item_t pop_data;
  logic            push;
  logic            push_ready;
  logic            pop_valid;
  logic            pop;

  ntdf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_mode        (in_mode),
    .in_start_cell  (in_start_cell),
    .in_digit_count (in_digit_count),
    .in_dot_place   (in_dot_place),
    .q_push         (push),
    .q_ready        (push_ready),
    .q_data         (push_data)
  );

  ntdf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  ntdf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (pop_valid),
    .q_pop        (pop),
    .q_data       (pop_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_cell_res (out_cell_res),
    .out_glyph    (out_glyph),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

/* design/ntdf_front.sv */
// ----------------------------------------------------------------------------
// Number to display text formatter: front end
// Accepts items, splits the value into digits and builds the slot glyphs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "number_to_display_text_formatter_core_macros.svh"

module ntdf_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [15:0]   in_value,
  input  wire logic [1:0]    in_mode,
  input  wire logic [4:0]    in_start_cell,
  input  wire logic [2:0]    in_digit_count,
  input  wire logic [1:0]    in_dot_place,
  output logic               q_push,
  input  wire logic          q_ready,
  output ntdf_pkg::item_t    q_data
);

  localparam logic [1:0] LAST_STEP = 2'd3;

  function automatic logic [16:0] dec_thr(input logic [1:0] s, input int unsigned j);
    logic [16:0] base;
    case (s)
      2'd0:    base = 17'd10000;
      2'd1:    base = 17'd1000;
      2'd2:    base = 17'd100;
      default: base = 17'd10;
    endcase
    return 17'(base * j);
  endfunction

  logic             busy_r;
  logic             done_r;
  logic [1:0]       step_r;
  logic [15:0]      rem_r;
  logic [4:0][3:0]  dig_r;
  logic             blank_r;
  logic [1:0]       dot_r;
  logic [2:0]       cnt_r;
  logic [4:0]       start_r;
  logic [4:0]       wmask_r;

  logic             acc;
  logic [3:0]       dcnt;
  logic [16:0]      dsub;
  logic [16:0]      diff;
  logic [2:0]       blank_lim;
  logic             blank_run;
  logic [4:0][7:0]  glyph;

  assign q_push   = busy_r && done_r && q_ready;
  assign in_ready = !busy_r || (done_r && q_ready);
  assign acc      = in_valid && in_ready;

  always_comb begin
    dcnt = 4'd0;
    dsub = 17'd0;
    for (int unsigned j = 1; j < 10; j++) begin
      if ({1'b0, rem_r} >= dec_thr(step_r, j)) begin
        dcnt = 4'(j);
        dsub = dec_thr(step_r, j);
      end
    end
    diff = {1'b0, rem_r} - dsub;
  end

  always_comb begin
    blank_lim = 3'd4 - {1'b0, dot_r};
    blank_run = blank_r;
    for (int k = 0; k < 5; k++) begin
      glyph[k] = ntdf_pkg::hex_glyph(dig_r[k]);
    end
    for (int k = 0; k < 4; k++) begin
      if (blank_run && (3'(k) < blank_lim) && (glyph[k] == ntdf_pkg::GLYPH_ZERO)) begin
        glyph[k] = ntdf_pkg::GLYPH_SPACE;
      end else begin
        blank_run = 1'b0;
      end
    end
  end

  always_comb begin
    q_data.start = start_r;
    q_data.count = cnt_r;
    q_data.dot   = dot_r;
    q_data.wmask = wmask_r;
    q_data.glyph = glyph;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (acc) begin
        busy_r  <= 1'b1;
        start_r <= in_start_cell;
        dot_r   <= in_dot_place;
        cnt_r   <= (in_digit_count > 3'd5) ? 3'd5 : in_digit_count;
        blank_r <= (in_mode == ntdf_pkg::MODE_BLANK);
        rem_r   <= in_value;
        step_r  <= 2'd0;
        if ((in_mode == ntdf_pkg::MODE_DEC) || (in_mode == ntdf_pkg::MODE_BLANK)) begin
          done_r  <= 1'b0;
          wmask_r <= 5'b11111;
        end else begin
          done_r   <= 1'b1;
          dig_r[1] <= in_value[15:12];
          dig_r[2] <= in_value[11:8];
          dig_r[3] <= in_value[7:4];
          dig_r[4] <= in_value[3:0];
          wmask_r  <= (in_value < 16'd256) ? 5'b11000 : 5'b11110;
        end
      end else if (q_push) begin
        busy_r <= 1'b0;
        done_r <= 1'b0;
      end else if (busy_r && !done_r) begin
        dig_r[step_r] <= dcnt;
        rem_r         <= diff[15:0];
        step_r        <= step_r + 2'd1;
        if (step_r == LAST_STEP) begin
          dig_r[4] <= diff[3:0];
          done_r   <= 1'b1;
        end
      end
    end
  end

  `NTDF_ASSERT(a_digits_done, clk, rst_n, (busy_r && !done_r && step_r == LAST_STEP && !acc) |=> done_r)

endmodule

`default_nettype wire

/* design/ntdf_queue.sv */
// ----------------------------------------------------------------------------
// Number to display text formatter: item queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "number_to_display_text_formatter_core_macros.svh"

module ntdf_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ntdf_pkg::item_t push_data,
  output logic               push_ready,
  output logic               pop_valid,
  input  wire logic          pop,
  output ntdf_pkg::item_t    pop_data
);

  ntdf_pkg::item_t ent_r [0:1];
  logic            wp_r;
  logic            rp_r;
  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = ent_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        ent_r[wp_r] <= push_data;
        wp_r        <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  `NTDF_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && (cnt_r == 2'd2))
  `NTDF_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && (cnt_r == 2'd0))

endmodule

`default_nettype wire

/* design/ntdf_back.sv */
// ----------------------------------------------------------------------------
// Number to display text formatter: back end
// Merges glyphs into the digit slots, places the dot and emits characters.
// ----------------------------------------------------------------------------
`default_nettype none

`include "number_to_display_text_formatter_core_macros.svh"

module ntdf_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_pop,
  input  wire ntdf_pkg::item_t q_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [5:0]         out_cell_res,
  output logic [7:0]         out_glyph,
  output logic               out_last
);

  logic [4:0][7:0]  slots_r;
  logic [4:0][7:0]  slots_nxt;
  logic [4:0][7:0]  merged;
  logic             busy_r;
  logic [2:0]       idx_r;
  logic [2:0]       cnt_r;
  logic [4:0]       start_r;
  logic             out_valid_r;
  logic [5:0]       out_cell_r;
  logic [7:0]       out_glyph_r;
  logic             out_last_r;

  logic             emit;
  logic             last_now;
  logic [2:0]       sel;

  assign emit     = busy_r && (!out_valid_r || out_ready);
  assign last_now = ((idx_r + 3'd1) == cnt_r);
  assign sel      = 3'(idx_r + 3'd5 - cnt_r);
  assign q_pop    = q_valid && (!busy_r || (emit && last_now));

  assign out_valid    = out_valid_r;
  assign out_cell_res = out_cell_r;
  assign out_glyph    = out_glyph_r;
  assign out_last     = out_last_r;

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      merged[k] = q_data.wmask[k] ? q_data.glyph[k] : slots_r[k];
    end
    slots_nxt = merged;
    if (q_data.dot != ntdf_pkg::DOT_NONE) begin
      slots_nxt[0] = merged[1];
      slots_nxt[1] = (q_data.dot == ntdf_pkg::DOT_THREE) ? ntdf_pkg::GLYPH_DOT : merged[2];
    end
    if (q_data.dot == ntdf_pkg::DOT_ONE) begin
      slots_nxt[2] = merged[3];
      slots_nxt[3] = ntdf_pkg::GLYPH_DOT;
    end
    if (q_data.dot == ntdf_pkg::DOT_TWO) begin
      slots_nxt[2] = ntdf_pkg::GLYPH_DOT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r     <= '0;
      busy_r      <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        out_cell_r  <= {1'b0, start_r} + {3'b0, idx_r};
        out_glyph_r <= slots_r[sel];
        out_last_r  <= last_now;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        slots_r <= slots_nxt;
        start_r <= q_data.start;
        cnt_r   <= q_data.count;
        idx_r   <= 3'd0;
        busy_r  <= (q_data.count != 3'd0);
      end else if (emit) begin
        idx_r <= idx_r + 3'd1;
        if (last_now) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  `NTDF_ASSERT(a_idx_in_range, clk, rst_n, busy_r |-> (idx_r < cnt_r))
  `NTDF_ASSERT(a_last_ends_item, clk, rst_n, (emit && last_now && !q_pop) |=> !busy_r)

endmodule

`default_nettype wire
